>>> sv/windowed_time_value_floor_store_top_defines.svh
// Assertion macros shared by the windowed time/value floor store RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef WINDOWED_TIME_VALUE_FLOOR_STORE_TOP_DEFINES_SVH
`define WINDOWED_TIME_VALUE_FLOOR_STORE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WTVF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wtvf: same-cycle check failed");
`define WTVF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wtvf: next-cycle check failed");
`else
`define WTVF_ASSERT_IMP(lbl, ante, cons)
`define WTVF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/wtvf_pkg.sv
// Package for the windowed time/value floor store: item types and codes.
// Used by the controller and the top level; no dependencies.
package wtvf_pkg;

    localparam int TIME_W  = 32;
    localparam int PRICE_W = 32;
    localparam int WLEN_W  = 13;
    localparam int STAT_W  = 2;
    localparam int WORD_W  = TIME_W + PRICE_W;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd4096;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BEFORE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [TIME_W-1:0]  time_stamp;
        logic [PRICE_W-1:0] price;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PRICE_W-1:0] found_price;
    } out_item_t;

endpackage

>>> sv/wtvf_mem.sv
// Simple dual-port entry memory with a registered read port.
// Holds {time, price} words of the circular entry table; no package use.
module wtvf_mem #(
    parameter int AW = 13,
    parameter int DW = 64
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/wtvf_ctrl.sv
// Sequencer of the floor store: window update, binary search, insert shift.
// Depends on wtvf_pkg and the assertion defines header, and drives the wtvf_mem ports of the top level.
`include "windowed_time_value_floor_store_top_defines.svh"
module wtvf_ctrl
    import wtvf_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int CAP        = MAX_WINDOW + 1,
    parameter int AW         = $clog2(CAP),
    parameter int CW         = $clog2(CAP + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WLEN_W-1:0] window_length,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output out_item_t         res_data,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [WORD_W-1:0] wr_data,
    output logic [AW-1:0]     rd_addr,
    input  logic [WORD_W-1:0] rd_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_SRCH  = 10'b0000000100,
        S_CMP   = 10'b0000001000,
        S_FLOOR = 10'b0000010000,
        S_EQ    = 10'b0000100000,
        S_SHRD  = 10'b0001000000,
        S_SHWR  = 10'b0010000000,
        S_QRD   = 10'b0100000000,
        S_RES   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_DROP  = 2'd0,
        PH_ADD   = 2'd1,
        PH_QUERY = 2'd2
    } phase_t;

    localparam logic [CW-1:0] CAP_C = CW'(CAP);
    localparam logic [32:0]   MAXW  = 33'(MAX_WINDOW);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [PRICE_W-1:0]  p_reg, p_next;
    logic [TIME_W-1:0]   ws_reg, ws_next;
    logic [TIME_W-1:0]   tgt_reg, tgt_next;
    logic                strict_reg, strict_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       idx_reg, idx_next;
    out_item_t           res_reg, res_next;

    logic [32:0]         len33;
    logic [32:0]         max_t;
    logic [TIME_W-1:0]   ws_new;
    logic [CW-1:0]       mid;
    logic [TIME_W-1:0]   rtime;
    logic [PRICE_W-1:0]  rprice;
    logic                go_right;
    logic [CW-1:0]       drop;

    always_comb begin
        if (window_length == '0) begin
            len33 = 33'd1;
        end else if (33'(window_length) > MAXW) begin
            len33 = MAXW;
        end else begin
            len33 = 33'(window_length);
        end
    end

    assign max_t    = {1'b0, ws_reg} + len33 - 33'd1;
    assign ws_new   = TIME_W'({1'b0, in_data.time_stamp} - len33 + 33'd1);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rtime    = rd_data[WORD_W-1:PRICE_W];
    assign rprice   = rd_data[PRICE_W-1:0];
    assign go_right = strict_reg ? (rtime <= tgt_reg) : (rtime < tgt_reg);
    assign drop     = lo_reg - CW'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RES);
    assign res_data  = res_reg;

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        t_next      = t_reg;
        p_next      = p_reg;
        ws_next     = ws_reg;
        tgt_next    = tgt_reg;
        strict_next = strict_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {t_reg, p_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    t_next = in_data.time_stamp;
                    p_next = in_data.price;
                    lo_next = '0;
                    hi_next = count_reg;
                    if (in_data.mode == MODE_ADD) begin
                        if ({1'b0, in_data.time_stamp} > max_t) begin
                            ws_next     = ws_new;
                            tgt_next    = ws_new;
                            strict_next = 1'b0;
                            phase_next  = PH_DROP;
                            state_next  = S_SRCH;
                        end else begin
                            state_next = S_START;
                        end
                    end else if (in_data.time_stamp < ws_reg) begin
                        res_next   = '{status: STAT_BEFORE, found_price: '0};
                        state_next = S_RES;
                    end else begin
                        tgt_next    = in_data.time_stamp;
                        strict_next = 1'b1;
                        phase_next  = PH_QUERY;
                        state_next  = S_SRCH;
                    end
                end
            end
            S_START: begin
                if (t_reg < ws_reg) begin
                    if (count_reg != '0) begin
                        rd_addr    = head_reg;
                        state_next = S_FLOOR;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg - AW'(1);
                        head_next  = head_reg - AW'(1);
                        count_next = count_reg + CW'(1);
                        state_next = S_IDLE;
                    end
                end else begin
                    tgt_next    = t_reg;
                    strict_next = 1'b0;
                    phase_next  = PH_ADD;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = S_SRCH;
                end
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    rd_addr    = head_reg + mid[AW-1:0];
                    mid_next   = mid;
                    state_next = S_CMP;
                end else begin
                    case (phase_reg)
                        PH_DROP: begin
                            if (lo_reg > CW'(1)) begin
                                head_next  = head_reg + drop[AW-1:0];
                                count_next = count_reg - drop;
                            end
                            state_next = S_START;
                        end
                        PH_ADD: begin
                            if (lo_reg < count_reg) begin
                                rd_addr    = head_reg + lo_reg[AW-1:0];
                                state_next = S_EQ;
                            end else begin
                                if (count_reg < CAP_C) begin
                                    wr_en      = 1'b1;
                                    wr_addr    = head_reg + count_reg[AW-1:0];
                                    count_next = count_reg + CW'(1);
                                end
                                state_next = S_IDLE;
                            end
                        end
                        default: begin
                            if (lo_reg == '0) begin
                                res_next   = '{status: STAT_NONE, found_price: '0};
                                state_next = S_RES;
                            end else begin
                                rd_addr    = head_reg + drop[AW-1:0];
                                state_next = S_QRD;
                            end
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (go_right) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_FLOOR: begin
                if (rtime < ws_reg) begin
                    if (t_reg >= rtime) begin
                        wr_en   = 1'b1;
                        wr_addr = head_reg;
                    end
                end else if (count_reg < CAP_C) begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg - AW'(1);
                    head_next  = head_reg - AW'(1);
                    count_next = count_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            S_EQ: begin
                state_next = S_IDLE;
                if (rtime == t_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = head_reg + lo_reg[AW-1:0];
                end else if (count_reg < CAP_C) begin
                    if (lo_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg - AW'(1);
                        head_next  = head_reg - AW'(1);
                        count_next = count_reg + CW'(1);
                    end else begin
                        idx_next   = count_reg;
                        state_next = S_SHRD;
                    end
                end
            end
            S_SHRD: begin
                if (idx_reg == lo_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg + lo_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end else begin
                    rd_addr    = head_reg + idx_reg[AW-1:0] - AW'(1);
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                wr_en      = 1'b1;
                wr_addr    = head_reg + idx_reg[AW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SHRD;
            end
            S_QRD: begin
                res_next   = '{status: STAT_FOUND, found_price: rprice};
                state_next = S_RES;
            end
            S_RES: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ws_reg    <= TIME_W'(1);
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            ws_reg    <= ws_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg  <= phase_next;
        t_reg      <= t_next;
        p_reg      <= p_next;
        tgt_reg    <= tgt_next;
        strict_reg <= strict_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
    end

    `WTVF_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CAP_C)
    `WTVF_ASSERT_IMP(a_cmp_range, state_reg == S_CMP, mid_reg < hi_reg && lo_reg <= mid_reg)
    `WTVF_ASSERT_IMP(a_shift_pos, state_reg == S_SHRD || state_reg == S_SHWR, idx_reg >= lo_reg)
    `WTVF_ASSERT_NXT(a_early_q, in_valid && in_ready && in_data.mode == MODE_QUERY && in_data.time_stamp < ws_reg, state_reg == S_RES && res_reg.status == STAT_BEFORE)

endmodule

>>> sv/windowed_time_value_floor_store_top.sv
// Top level of the windowed time/value floor store: ports, config, result register.
// Depends on wtvf_pkg, wtvf_mem and wtvf_ctrl.
//
//   channel   ports                    carries
//   input     s_valid s_ready s_data   in_item_t (mode, time_stamp, price)
//   result    m_valid m_ready m_data   out_item_t (status, found_price), queries only
//   config    cfg_we cfg_wdata         window_length, no wait
//
// A binary search probes the single-read-port table memory once per step: S_SRCH reads,
// S_CMP compares and narrows the range; an add may run two searches.
// An add that lands inside the table shifts the later entries, each read in S_SHRD and written in S_SHWR.
// A query runs at most one search, then reads the floor entry in S_QRD; an add yields no item.
// Reset is synchronous; the table needs no clearing.
// The result register takes a new item as soon as the previous one is taken.
module windowed_time_value_floor_store_top
    import wtvf_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [WLEN_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    localparam int CAP = MAX_WINDOW + 1;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    logic [WLEN_W-1:0] wlen_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
        end else if (cfg_we) begin
            wlen_reg <= cfg_wdata;
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    wtvf_ctrl #(
        .MAX_WINDOW (MAX_WINDOW),
        .CAP        (CAP),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window_length (wlen_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_data       (s_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    wtvf_mem #(
        .AW (AW),
        .DW (WORD_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
